FILE: design/pfld_pkg.sv
`default_nettype none

package pfld_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int IDX_W        = 17;
  localparam int ERR_W        = 11;

  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_LINE  = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic sweep_zero;
    logic rd_pixel;
    logic wr_pixel;
    logic step;
    logic rd_byte;
    logic load_result;
  } pfld_cmd_t;

  typedef struct packed {
    action_t act;
    logic    on_panel;
    logic    line_last;
    logic    sweep_last;
    logic    rsp_busy;
  } pfld_sts_t;

endpackage

`default_nettype wire

FILE: design/pfld_ctrl.sv
`default_nettype none

module pfld_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cmd_valid,
  output logic                 cmd_stall,
  input  pfld_pkg::pfld_sts_t  sts,
  output pfld_pkg::pfld_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PLOT_RD,
    S_PLOT_WR,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign cmd_stall = rst | (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.act)
          pfld_pkg::ACT_PIXEL: state_next = sts.on_panel ? S_PLOT_RD : S_DONE;
          pfld_pkg::ACT_LINE:  state_next = S_PLOT_RD;
          pfld_pkg::ACT_FILL:  state_next = S_FILL;
          pfld_pkg::ACT_READ: begin
            cmd.rd_byte = 1'b1;
            state_next  = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_PLOT_RD: begin
        if (sts.on_panel) begin
          cmd.rd_pixel = 1'b1;
          state_next   = S_PLOT_WR;
        end else if (sts.act == pfld_pkg::ACT_LINE && !sts.line_last) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PLOT_WR: begin
        cmd.wr_pixel = 1'b1;
        if (sts.act == pfld_pkg::ACT_LINE && !sts.line_last) begin
          cmd.step   = 1'b1;
          state_next = S_PLOT_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.rsp_busy) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/pfld_dp.sv
`default_nettype none

module pfld_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  [1:0]           action,
  input  wire  [7:0]           start_x,
  input  wire  [7:0]           start_y,
  input  wire  [7:0]           end_x,
  input  wire  [7:0]           end_y,
  input  wire                  ink,
  input  wire  [9:0]           byte_index,
  input  pfld_pkg::pfld_cmd_t  cmd,
  output pfld_pkg::pfld_sts_t  sts,
  input  wire                  rsp_stall,
  output logic                 rsp_valid,
  output logic                 status,
  output logic [7:0]           read_value
);

  localparam int AW = pfld_pkg::ADDR_W;
  localparam int IW = pfld_pkg::IDX_W;
  localparam int EW = pfld_pkg::ERR_W;

  logic [7:0] mem [pfld_pkg::STORE_BYTES];
  logic [7:0] rdata;

  pfld_pkg::action_t act;
  logic              ink_r;
  logic [7:0]        cur_x;
  logic [7:0]        cur_y;
  logic [7:0]        tgt_x;
  logic [7:0]        tgt_y;
  logic [7:0]        dx;
  logic [7:0]        dy;
  logic              sx_neg;
  logic              sy_neg;
  logic signed [EW-1:0] err;
  logic [9:0]        byte_idx;
  logic [AW-1:0]     sweep_cnt;

  logic [7:0]        dx_in;
  logic [7:0]        dy_in;
  logic [IW-1:0]     idx_full;
  logic [AW-1:0]     pix_addr;
  logic [IW-1:0]     byte_full;
  logic              byte_ok;
  logic              on_panel;
  logic signed [EW:0] e2;
  logic signed [EW:0] dx_s;
  logic signed [EW:0] dy_s;
  logic              go_x;
  logic              go_y;
  logic [7:0]        mask;
  logic [7:0]        wdata;
  logic [AW-1:0]     waddr;
  logic              we;
  logic [AW-1:0]     raddr;
  logic              re;

  function automatic logic [7:0] FILL_BYTE(input logic zero, input logic white);
    FILL_BYTE = (!zero && white) ? pfld_pkg::FILL_WHITE : pfld_pkg::FILL_BLACK;
  endfunction

  assign dx_in = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
  assign dy_in = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);

  assign idx_full = IW'(cur_x) + IW'(cur_y >> 3) * IW'(pfld_pkg::PANEL_WIDTH);
  assign pix_addr = idx_full[AW-1:0];
  assign on_panel = ({1'b0, cur_x} < 9'(pfld_pkg::PANEL_WIDTH))
                 && ({1'b0, cur_y} < 9'(pfld_pkg::PANEL_HEIGHT))
                 && (idx_full < IW'(pfld_pkg::STORE_BYTES));

  assign byte_full = IW'(byte_idx);
  assign byte_ok   = byte_full < IW'(pfld_pkg::STORE_BYTES);

  assign e2   = {err, 1'b0};
  assign dx_s = (EW+1)'(dx);
  assign dy_s = (EW+1)'(dy);
  assign go_x = e2 > -dy_s;
  assign go_y = e2 < dx_s;

  assign mask = 8'(1) << cur_y[2:0];

  always_comb begin
    we    = 1'b0;
    waddr = sweep_cnt;
    wdata = FILL_BYTE(cmd.sweep_zero, ink_r);
    if (cmd.sweep) begin
      we = 1'b1;
    end else if (cmd.wr_pixel) begin
      we    = 1'b1;
      waddr = pix_addr;
      wdata = ink_r ? (rdata | mask) : (rdata & ~mask);
    end
    re    = cmd.rd_pixel | cmd.rd_byte;
    raddr = cmd.rd_byte ? byte_full[AW-1:0] : pix_addr;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.load) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= pfld_pkg::action_t'(action);
      ink_r    <= ink;
      cur_x    <= start_x;
      cur_y    <= start_y;
      tgt_x    <= end_x;
      tgt_y    <= end_y;
      dx       <= dx_in;
      dy       <= dy_in;
      sx_neg   <= !(start_x < end_x);
      sy_neg   <= !(start_y < end_y);
      err      <= EW'(signed'({1'b0, dx_in})) - EW'(signed'({1'b0, dy_in}));
      byte_idx <= byte_index;
    end else if (cmd.step) begin
      if (go_x) begin
        cur_x <= sx_neg ? cur_x - 8'd1 : cur_x + 8'd1;
      end
      if (go_y) begin
        cur_y <= sy_neg ? cur_y - 8'd1 : cur_y + 8'd1;
      end
      err <= EW'(e2 >>> 1) - (go_x ? EW'(dy_s) : EW'(0)) + (go_y ? EW'(dx_s) : EW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status     <= (act == pfld_pkg::ACT_PIXEL) && !on_panel;
      read_value <= (act == pfld_pkg::ACT_READ && byte_ok) ? rdata : 8'h00;
    end
  end

  always_comb begin
    sts.act        = act;
    sts.on_panel   = on_panel;
    sts.line_last  = (cur_x == tgt_x) && (cur_y == tgt_y);
    sts.sweep_last = sweep_cnt == AW'(pfld_pkg::STORE_BYTES - 1);
    sts.rsp_busy   = rsp_valid & rsp_stall;
  end

endmodule

`default_nettype wire

FILE: design/page_framebuffer_line_draw_top.sv
// Channel   Handshake              Fields
// cmd       cmd_valid / cmd_stall  action start_x start_y end_x end_y ink byte_index
// rsp       rsp_valid / rsp_stall  status read_value
//
// One transaction at a time. A pixel is read and written only when on panel, a
// line steps over off-panel pixels, a read fetches one byte, and a fill writes one
// byte per cycle through the store's write port. Each plotted pixel is a read and
// a write of the frame store, which has one read port and one write port. After
// reset the store's STORE_BYTES (1024 by default) bytes are cleared with cmd_stall
// high. A new command is taken while a result waits under rsp_stall.
`default_nettype none

module page_framebuffer_line_draw_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        cmd_valid,
  output logic       cmd_stall,
  input  wire  [1:0] action,
  input  wire  [7:0] start_x,
  input  wire  [7:0] start_y,
  input  wire  [7:0] end_x,
  input  wire  [7:0] end_y,
  input  wire        ink,
  input  wire  [9:0] byte_index,
  output logic       rsp_valid,
  input  wire        rsp_stall,
  output logic       status,
  output logic [7:0] read_value
);

  pfld_pkg::pfld_cmd_t cmd;
  pfld_pkg::pfld_sts_t sts;

  pfld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfld_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .ink        (ink),
    .byte_index (byte_index),
    .cmd        (cmd),
    .sts        (sts),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .status     (status),
    .read_value (read_value)
  );

endmodule

`default_nettype wire

FILE: design/pfld_checker.sv
`default_nettype none

module pfld_checker (
  input wire       clk,
  input wire       rst,
  input wire       cmd_valid,
  input wire       cmd_stall,
  input wire       rsp_valid,
  input wire       rsp_stall,
  input wire       status,
  input wire [7:0] read_value
);

  // store clear pass keeps commands out after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> cmd_stall && !rsp_valid)
    else $error("command taken or result shown right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second command taken while one is in work");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> read_value == 8'h00)
    else $error("error result carries read data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(read_value))
    else $error("stalled result changed");

endmodule

bind page_framebuffer_line_draw_top pfld_checker u_chk (.*);

`default_nettype wire
